// ===== rtl/vertex_normal_average_core_assert.svh =====
// Assertion macros used by the checker file of the vertex normal core
`ifndef VERTEX_NORMAL_AVERAGE_CORE_ASSERT_SVH
`define VERTEX_NORMAL_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define VNA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VNA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vna_pkg.sv =====
// Types and constants of the vertex normal averaging core
package vna_pkg;

    localparam int COMP_W  = 32;
    localparam int SUM_W   = 36;
    localparam int HALF_W  = 18;
    localparam int ACC_W   = 74;
    localparam int REM_W   = 40;
    localparam int ROOT_W  = 37;
    localparam int QUO_W   = 17;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(8);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [COMP_W-1:0] MIN_SQ_RESET = COMP_W'(1);

    typedef struct packed {
        logic signed [COMP_W-1:0] face_x;
        logic signed [COMP_W-1:0] face_y;
        logic signed [COMP_W-1:0] face_z;
        logic                     last_face;
    } face_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
        logic                     used_fallback;
    } normal_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_SQR,
        ST_CHECK,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/vna_mul.sv =====
// Shared 18x18 unsigned multiplier with registered product
module vna_mul
    import vna_pkg::*;
(
    input  logic                  aclk,
    input  logic [HALF_W-1:0]     op_a,
    input  logic [HALF_W-1:0]     op_b,
    output logic [2*HALF_W-1:0]   prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

// ===== rtl/vna_sub.sv =====
// Shared compare and subtract unit for square root and division steps
module vna_sub
    import vna_pkg::*;
(
    input  logic [REM_W-1:0] op_a,
    input  logic [REM_W-1:0] op_b,
    output logic [REM_W-1:0] diff,
    output logic             ge
);

    logic borrow;

    assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
    assign ge = ~borrow;

endmodule

// ===== rtl/vertex_normal_average_core.sv =====
// Top level: area weighted vertex normal from a stream of face normals
//
//  channel | ports              | word
//  --------+--------------------+-------------------------------------
//  input   | s_valid s_ready    | face_t: face normal, last_face flag
//  result  | m_valid m_ready    | normal_t: vertex normal, fallback flag
//  config  | cfg_valid cfg_ready| min_squared_length, 32 bit
//
// Non-last faces are taken one per cycle. A last face starts the end sequence:
// squares on the 18x18 multiplier, 1 compare, 37 square root steps
// and 3 x 17 divide steps on the shared subtractor (only squares and compare on fallback),
// then the word waits in the output register until taken.
// Synchronous active-low reset; no input word is taken until the result leaves.
module vertex_normal_average_core
    import vna_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  face_t             s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output normal_t           m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COMP_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic signed [SUM_W-1:0]  sum_reg   [3];
    logic signed [COMP_W-1:0] first_reg [3];
    logic signed [COMP_W-1:0] res_reg   [3];
    logic                     fb_reg;
    logic                     start_reg;
    logic [COMP_W-1:0]        min_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [QUO_W-2:0]         quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               comp_reg;
    logic [1:0]               part_reg;

    logic [SUM_W-1:0]         mag [3];
    logic signed [COMP_W-1:0] face [3];
    logic                     accept;

    // multiplier
    logic [1:0]               sq_comp, sq_part;
    logic [HALF_W-1:0]        mul_a, mul_b;
    logic [2*HALF_W-1:0]      prod_reg;
    logic [ACC_W-1:0]         prod_sh;

    // subtractor
    logic [REM_W-1:0]         sub_a, sub_b, sub_diff;
    logic                     sub_ge;
    logic [REM_W-1:0]         rem2;
    logic [QUO_W-1:0]         quo_full;
    logic [COMP_W-1:0]        quo_ext;
    logic                     fallback;

    assign face[0] = s_data.face_x;
    assign face[1] = s_data.face_y;
    assign face[2] = s_data.face_z;
    assign accept  = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = sum_reg[i][SUM_W-1] ? SUM_W'(-sum_reg[i]) : SUM_W'(sum_reg[i]);
        end
    end

    // square product schedule: three partial products per component
    always_comb begin
        if (cnt_reg >= CNT_W'(6)) begin
            sq_comp = 2'd2;
            sq_part = 2'(cnt_reg - CNT_W'(6));
        end else if (cnt_reg >= CNT_W'(3)) begin
            sq_comp = 2'd1;
            sq_part = 2'(cnt_reg - CNT_W'(3));
        end else begin
            sq_comp = 2'd0;
            sq_part = 2'(cnt_reg);
        end
    end

    always_comb begin
        case (sq_part)
            2'd0: begin
                mul_a = mag[sq_comp][HALF_W-1:0];
                mul_b = mag[sq_comp][HALF_W-1:0];
            end
            2'd1: begin
                mul_a = mag[sq_comp][SUM_W-1:HALF_W];
                mul_b = mag[sq_comp][HALF_W-1:0];
            end
            default: begin
                mul_a = mag[sq_comp][SUM_W-1:HALF_W];
                mul_b = mag[sq_comp][SUM_W-1:HALF_W];
            end
        endcase
    end

    vna_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    // cross term counts twice, hence shift by HALF_W + 1
    always_comb begin
        case (part_reg)
            2'd0:    prod_sh = ACC_W'(prod_reg);
            2'd1:    prod_sh = ACC_W'(prod_reg) << (HALF_W + 1);
            default: prod_sh = ACC_W'(prod_reg) << (2 * HALF_W);
        endcase
    end

    assign rem2 = {rem_reg[REM_W-3:0], rad_reg[ACC_W-1:ACC_W-2]};

    always_comb begin
        if (state_reg == ST_ROOT) begin
            sub_a = rem2;
            sub_b = REM_W'({root_reg, 2'b01});
        end else begin
            sub_a = (cnt_reg == '0) ? REM_W'(mag[comp_reg])
                                    : {rem_reg[REM_W-2:0], 1'b0};
            sub_b = REM_W'(root_reg);
        end
    end

    vna_sub u_sub (
        .op_a (sub_a),
        .op_b (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    assign quo_full = {quo_reg, sub_ge};
    assign quo_ext  = COMP_W'(quo_full);
    assign fallback = (acc_reg == '0) || (acc_reg < ACC_W'(min_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: if (accept && s_data.last_face) state_next = ST_SQR;
            ST_SQR:   if (cnt_reg == SQR_LAST + CNT_W'(1)) state_next = ST_CHECK;
            ST_CHECK: state_next = fallback ? ST_OUT : ST_ROOT;
            ST_ROOT:  if (cnt_reg == ROOT_LAST) state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == DIV_LAST && comp_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_ACCUM;
            default:  state_next = ST_ACCUM;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_ACCUM: s_ready = 1'b1;
            ST_OUT:   m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_data.normal_x      = res_reg[0];
    assign m_data.normal_y      = res_reg[1];
    assign m_data.normal_z      = res_reg[2];
    assign m_data.used_fallback = fb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            start_reg <= 1'b1;
            min_reg   <= MIN_SQ_RESET;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            part_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]   <= '0;
                first_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) min_reg <= cfg_data;
            case (state_reg)
                ST_ACCUM: begin
                    if (accept) begin
                        for (int i = 0; i < 3; i++) begin
                            if (start_reg) begin
                                first_reg[i] <= face[i];
                                sum_reg[i]   <= SUM_W'(face[i]);
                            end else begin
                                logic signed [SUM_W:0] s;
                                s = (SUM_W+1)'(sum_reg[i]) + (SUM_W+1)'(face[i]);
                                if (s[SUM_W] != s[SUM_W-1])
                                    sum_reg[i] <= s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                           : {1'b0, {(SUM_W-1){1'b1}}};
                                else
                                    sum_reg[i] <= s[SUM_W-1:0];
                            end
                        end
                        start_reg <= s_data.last_face;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                    end
                end
                ST_SQR: begin
                    // product issued at cnt is added to the sum in the next cycle
                    part_reg <= sq_part;
                    if (cnt_reg != '0) acc_reg <= acc_reg + prod_sh;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_CHECK: begin
                    fb_reg   <= fallback;
                    rad_reg  <= acc_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                    comp_reg <= '0;
                    if (fallback) begin
                        for (int i = 0; i < 3; i++) res_reg[i] <= first_reg[i];
                    end
                end
                ST_ROOT: begin
                    rad_reg  <= rad_reg << 2;
                    rem_reg  <= sub_ge ? sub_diff : rem2;
                    root_reg <= {root_reg[ROOT_W-2:0], sub_ge};
                    cnt_reg  <= (cnt_reg == ROOT_LAST) ? '0 : cnt_reg + CNT_W'(1);
                end
                ST_DIV: begin
                    rem_reg <= sub_ge ? sub_diff : sub_a;
                    quo_reg <= quo_full[QUO_W-2:0];
                    if (cnt_reg == DIV_LAST) begin
                        res_reg[comp_reg] <= sum_reg[comp_reg][SUM_W-1] ? -quo_ext : quo_ext;
                        cnt_reg  <= '0;
                        comp_reg <= comp_reg + 2'd1;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

endmodule

// ===== rtl/vna_checker.sv =====
// Port-level checks of the vertex normal core, bound to the top level
`include "vertex_normal_average_core_assert.svh"

module vna_checker
    import vna_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input face_t   s_data,
    input logic    m_valid,
    input logic    m_ready,
    input normal_t m_data
);

    `VNA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    `VNA_ASSERT_NOW(a_one_vertex, aclk, aresetn, m_valid, !s_ready, "input taken while a result waits")
    `VNA_ASSERT_NEXT(a_accum_ready, aclk, aresetn, s_valid && s_ready && !s_data.last_face, s_ready, "not ready after an inner face")
    `VNA_ASSERT_NEXT(a_no_instant, aclk, aresetn, s_valid && s_ready && s_data.last_face, !m_valid && !s_ready, "end sequence skipped")

endmodule

bind vertex_normal_average_core vna_checker u_vna_checker (.*);

// ===== verif/vertex_normal_average_core_tb.sv =====
// Self-checking testbench of the vertex normal averaging core
module vertex_normal_average_core_tb;
    import vna_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    face_t             s_data;
    logic              m_valid;
    logic              m_ready;
    normal_t           m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [COMP_W-1:0] cfg_data;

    vertex_normal_average_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        face_t   face;
        bit      typed;
        normal_t normal;
    } face_row_t;

    // predictor state
    longint            acc_sum [3];
    logic [COMP_W-1:0] first_face [3];
    bit                new_vertex;
    logic [COMP_W-1:0] min_sq_len;

    normal_t     pending_normals [$];
    int          error_count;
    int          idle_cycles;
    int          faces_sent;
    int          normals_seen;
    int          fallback_seen;
    bit          no_idle;
    bit          timed_out;
    face_row_t   directed [$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // accumulate one face; returns 1 with the vertex normal on a last face
    function automatic bit average_face(input face_t f, output normal_t n);
        longint            comp [3];
        longint            s;
        longint unsigned   mag;
        longint unsigned   q;
        logic [73:0]       sq_len;
        logic [73:0]       cand;
        logic [36:0]       root;
        comp[0] = longint'(f.face_x);
        comp[1] = longint'(f.face_y);
        comp[2] = longint'(f.face_z);
        n = '0;
        for (int i = 0; i < 3; i++) begin
            if (new_vertex) begin
                first_face[i] = comp[i][31:0];
                acc_sum[i]    = comp[i];
            end else begin
                s = acc_sum[i] + comp[i];
                if (s > 64'sd34359738367) s = 64'sd34359738367;
                if (s < -64'sd34359738368) s = -64'sd34359738368;
                acc_sum[i] = s;
            end
        end
        new_vertex = 1'b0;
        if (!f.last_face) return 1'b0;
        new_vertex = 1'b1;
        sq_len = '0;
        for (int i = 0; i < 3; i++) begin
            mag = (acc_sum[i] < 0) ? longint'(-acc_sum[i]) : acc_sum[i];
            sq_len += 74'(mag) * 74'(mag);
        end
        if (sq_len == 0 || sq_len < 74'(min_sq_len)) begin
            n.normal_x      = first_face[0];
            n.normal_y      = first_face[1];
            n.normal_z      = first_face[2];
            n.used_fallback = 1'b1;
            return 1'b1;
        end
        root = '0;
        for (int b = 36; b >= 0; b--) begin
            cand = 74'(root | (37'd1 << b));
            if (cand * cand <= sq_len) root = cand[36:0];
        end
        for (int i = 0; i < 3; i++) begin
            mag = (acc_sum[i] < 0) ? longint'(-acc_sum[i]) : acc_sum[i];
            q   = (mag << 16) / 64'(root);
            if (acc_sum[i] < 0) q = -q;
            if (i == 0) n.normal_x = q[31:0];
            if (i == 1) n.normal_y = q[31:0];
            if (i == 2) n.normal_z = q[31:0];
        end
        n.used_fallback = 1'b0;
        return 1'b1;
    endfunction

    task automatic random_idle();
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge aclk);
    endtask

    task automatic send_face(input face_t f, input bit typed, input normal_t typed_normal);
        normal_t n;
        s_valid = 1'b1;
        s_data  = f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (average_face(f, n)) pending_normals.push_back(typed ? typed_normal : n);
        faces_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_normals.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [COMP_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        min_sq_len = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [COMP_W-1:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 32'(int'($urandom_range(0, 262143)) - 131072);
            1: return $urandom();
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            3: return '0;
            default: return 32'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic random_vertex();
        int       faces;
        face_t    f;
        face_t    first;
        normal_t  none;
        none = '0;
        case ($urandom_range(0, 9))
            0: faces = $urandom_range(14, 20);   // long lists reach saturation
            1: faces = 2;
            default: faces = $urandom_range(1, 6);
        endcase
        for (int k = 0; k < faces; k++) begin
            random_idle();
            f.face_x = random_comp();
            f.face_y = random_comp();
            f.face_z = random_comp();
            // opposite pair cancels to a zero sum
            if (faces == 2 && k == 1 && $urandom_range(0, 1)) begin
                f.face_x = -first.face_x;
                f.face_y = -first.face_y;
                f.face_z = -first.face_z;
            end
            if (k == 0) first = f;
            f.last_face = (k == faces - 1);
            send_face(f, 1'b0, none);
        end
    endtask

    function automatic face_row_t row(input logic [31:0] x, y, z, input bit last,
                                      input bit typed, input logic [31:0] nx, ny, nz,
                                      input bit fb);
        face_row_t r;
        r.face   = '{x, y, z, last};
        r.typed  = typed;
        r.normal = '{nx, ny, nz, fb};
        return r;
    endfunction

    // result side: random back pressure
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            m_ready = 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
                m_ready = 1'b1;
            end
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        normal_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_normals.size() == 0) begin
                $error("unexpected result word %h", m_data);
                error_count++;
            end else begin
                e = pending_normals.pop_front();
                normals_seen++;
                if (e.used_fallback) fallback_seen++;
                if (m_data.normal_x !== e.normal_x) begin
                    $error("normal_x expected %h actual %h", e.normal_x, m_data.normal_x);
                    error_count++;
                end
                if (m_data.normal_y !== e.normal_y) begin
                    $error("normal_y expected %h actual %h", e.normal_y, m_data.normal_y);
                    error_count++;
                end
                if (m_data.normal_z !== e.normal_z) begin
                    $error("normal_z expected %h actual %h", e.normal_z, m_data.normal_z);
                    error_count++;
                end
                if (m_data.used_fallback !== e.used_fallback) begin
                    $error("used_fallback expected %b actual %b",
                           e.used_fallback, m_data.used_fallback);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [COMP_W-1:0] thresholds [5];
        face_row_t         one_row;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        idle_cycles = 0;
        faces_sent  = 0;
        normals_seen  = 0;
        fallback_seen = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc_sum[i]    = 0;
            first_face[i] = '0;
        end
        new_vertex = 1'b1;
        min_sq_len = MIN_SQ_RESET;

        // directed words at the reset threshold
        directed.push_back(row(0, 0, 0, 1, 1, 0, 0, 0, 1));
        directed.push_back(row(32'h10000, 0, 0, 1, 1, 32'h10000, 0, 0, 0));
        directed.push_back(row(0, 32'hffff0000, 0, 1, 1, 0, 32'hffff0000, 0, 0));
        directed.push_back(row(32'h7fffffff, 0, 0, 1, 1, 32'h10000, 0, 0, 0));
        directed.push_back(row(0, 0, 32'h80000000, 1, 1, 0, 0, 32'hffff0000, 0));
        directed.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(32'hffffffff, 0, 0, 1, 1, 1, 0, 0, 1));
        directed.push_back(row(1, 0, 0, 1, 1, 32'h10000, 0, 0, 0));
        directed.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0, 0, 0, 0, 0));
        directed.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 1, 0, 0, 0, 0, 0));
        directed.push_back(row(32'h30000, 32'hfffc0000, 32'h1234, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(32'h7fffffff, 32'h80000000, 32'h5555aaaa, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(32'haaaa5555, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0, 0, 0));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) begin
            random_idle();
            send_face(directed[i].face, directed[i].typed, directed[i].normal);
        end

        // zero threshold: zero sum still falls back
        write_threshold('0);
        one_row = row(0, 0, 0, 1, 1, 0, 0, 0, 1);
        send_face(one_row.face, 1'b1, one_row.normal);
        // top threshold: a small sum falls back
        write_threshold('1);
        one_row = row(1000, 0, 0, 1, 1, 1000, 0, 0, 1);
        send_face(one_row.face, 1'b1, one_row.normal);

        thresholds[0] = MIN_SQ_RESET;
        thresholds[1] = '0;
        thresholds[2] = '1;
        thresholds[3] = $urandom();
        thresholds[4] = 32'(1) << $urandom_range(0, 31);
        for (int p = 0; p < 5; p++) begin
            write_threshold(thresholds[p]);
            for (int v = 0; v < 50; v++) begin
                if (p == 2 && v == 35) wait_drained();
                if (p == 4 && v == 40) no_idle = 1'b1;
                random_vertex();
            end
        end

        wait_drained();
        $display("sent %0d faces, checked %0d vertex normals (%0d on fallback)",
                 faces_sent, normals_seen, fallback_seen);
        $display("five thresholds including zero and all ones, lists of 1 to 20 faces");
        if (error_count == 0 && pending_normals.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== vertex_normal_average_core.f =====
+incdir+rtl
rtl/vna_pkg.sv
rtl/vna_mul.sv
rtl/vna_sub.sv
rtl/vertex_normal_average_core.sv
rtl/vna_checker.sv
verif/vertex_normal_average_core_tb.sv
